### hw/rtl/assert_macros.svh
// assertion macros used by the shp3x3 checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define SHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shp3x3 check failed");

// next-cycle implication, off while reset is held
`define SHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shp3x3 check failed");

// next-cycle implication that also runs through reset
`define SHP_ASSERT_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("shp3x3 check failed");

`endif

### hw/rtl/shp3x3_pkg.sv
package shp3x3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 11;
  localparam int ROW_W     = 16;
  localparam int CW_W      = 12;
  localparam int CFG_W     = 16;
  localparam int PIX_W     = 24;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - ROW_W - COL_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [FIFO_CW:0] FIFO_ROOM = (FIFO_CW + 1)'(FIFO_DEPTH - 2);

  localparam logic [CW_W-1:0]  W_LO      = CW_W'(3);
  localparam logic [CW_W-1:0]  W_HI      = CW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] H_LO      = ROW_W'(3);
  localparam logic [CW_W-1:0]  W_RST     = CW_W'(640);
  localparam logic [ROW_W-1:0] H_RST     = ROW_W'(480);

  // configuration register indexes
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef struct packed {
    pix_t two;
    pix_t one;
  } line_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    line_ent_t         wr_data;
  } line_req_t;

  typedef struct packed {
    pix_t             pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic two;
    res_t first;
    res_t second;
  } fifo_push_t;

  function automatic chan_t sharpen_ch(chan_t ctr, chan_t up, chan_t dn, chan_t lf, chan_t rt);
    logic [10:0]        five;
    logic [9:0]         nsum;
    logic signed [11:0] v;
    chan_t              res;
    five = {1'b0, ctr, 2'b00} + {3'b000, ctr};
    nsum = {2'b00, up} + {2'b00, dn} + {2'b00, lf} + {2'b00, rt};
    v = $signed({1'b0, five}) - $signed({2'b00, nsum});
    if (v < 12'sd0) begin
      res = 8'h00;
    end else if (v > 12'sd255) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic pix_t sharpen_px(pix_t ctr, pix_t up, pix_t dn, pix_t lf, pix_t rt);
    pix_t res;
    res.red   = sharpen_ch(ctr.red, up.red, dn.red, lf.red, rt.red);
    res.green = sharpen_ch(ctr.green, up.green, dn.green, lf.green, rt.green);
    res.blue  = sharpen_ch(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
    return res;
  endfunction

endpackage

### hw/rtl/shp3x3_line_mem.sv
module shp3x3_line_mem
  import shp3x3_pkg::*;
(
  input  logic      clk,
  input  line_req_t req,
  output line_ent_t rd_a,
  output line_ent_t rd_b
);

  // each entry holds the pixel two rows back and one row back at that column
  line_ent_t mem_r [MAX_WIDTH];
  line_ent_t rd_a_r;
  line_ent_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_r <= mem_r[req.rd_addr_a];
      rd_b_r <= mem_r[req.rd_addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### hw/rtl/shp3x3_out_fifo.sv
module shp3x3_out_fifo
  import shp3x3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fifo_push_t         push,
  input  logic               pop,
  output res_t               head,
  output logic [FIFO_CW-1:0] level
);

  res_t               buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;
  logic [FIFO_CW-1:0] push_n;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);

  always_comb begin
    push_n = '0;
    if (push.valid) begin
      push_n = push.two ? FIFO_CW'(2) : FIFO_CW'(1);
    end
    wr_ptr_nxt = wr_ptr_r + push_n[FIFO_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + push_n - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      buf_r[wr_ptr_r] <= push.first;
      if (push.two) begin
        buf_r[wr_ptr_p1] <= push.second;
      end
    end
  end

  assign head  = buf_r[rd_ptr_r];
  assign level = cnt_r;

endmodule

### hw/rtl/sharpen_3x3_rgb_filter.sv
// 3x3 laplacian sharpen for a raster rgb pixel stream. One pixel is taken per clock while
// the output queue has room. Each interior pixel becomes 5x its centre minus its four direct
// neighbours per channel, clamped to 0..255; the first and last rows and columns pass
// through unchanged. The pixel at (r, c) completes the result at (r-1, c), which is
// registered and leaves through an 8-entry output queue; row 0 pixels leave as they arrive,
// and each pixel of the last row adds a second result of its own, so the single output port
// slows the last row. The line memory stores the two previous rows per column and is read
// at the column and the next column and written back in the next cycle, with the write of
// the previous pixel forwarded. The line memory is not cleared: after reset or a width
// increase, the rows above must be sent before they are used. Width (3..2048) and height
// (at least 3) must be written on the cfg port while idle; the block does not check it.
module sharpen_3x3_rgb_filter
  import shp3x3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  input  logic                   in_tuser,   // frame_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_red, out_green, out_blue, out_row, out_col
  output logic                   out_tlast   // last_in_run
);

  logic [CW_W-1:0]  width_r;
  logic [ROW_W-1:0] height_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;

  logic [CW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             in_acc;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             is_top;
  logic             is_bot;
  logic             is_border;
  pix_t             cur_px;

  logic              s1_valid_r;
  pix_t              s1_cur_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ADDR_W-1:0] s1_colp1_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_top_r;
  logic              s1_bot_r;
  logic              s1_border_r;

  logic              fw_valid_r;
  logic [ADDR_W-1:0] fw_addr_r;
  line_ent_t         fw_data_r;
  pix_t              left_r;

  line_req_t         mem_req;
  line_ent_t         rd_a;
  line_ent_t         rd_b;
  line_ent_t         ent;
  pix_t              ctr;
  pix_t              rt;
  pix_t              sharp;

  fifo_push_t         push;
  res_t               head;
  logic [FIFO_CW-1:0] level;

  // effective frame size
  always_comb begin
    if (width_r < W_LO) begin
      w_eff = W_LO;
    end else if (width_r > W_HI) begin
      w_eff = W_HI;
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < H_LO) ? H_LO : height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= W_RST;
      height_r <= H_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[CW_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
        default:    ;
      endcase
    end
  end

  assign in_tready = ({1'b0, level} + (s1_valid_r ? (FIFO_CW + 1)'(2) : (FIFO_CW + 1)'(0)))
                     <= FIFO_ROOM;
  assign in_acc    = in_tvalid & in_tready;
  assign cur_px    = in_tdata[PIX_W-1:0] == '0 ? '0 :
                     {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};

  always_comb begin
    col_cur   = in_tuser ? '0 : col_r;
    row_cur   = in_tuser ? '0 : row_r;
    col_inc   = {1'b0, col_cur} + (COL_W + 1)'(1);
    row_inc   = {1'b0, row_cur} + (ROW_W + 1)'(1);
    is_top    = (row_cur == '0);
    is_bot    = (row_cur >= h_eff - ROW_W'(1));
    is_border = (row_cur == ROW_W'(1)) || (row_cur >= h_eff) || (col_cur == '0) ||
                ({1'b0, col_cur} >= w_eff - CW_W'(1));
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r <= in_acc;
      fw_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r    <= cur_px;
      s1_col_r    <= col_cur;
      s1_colp1_r  <= col_inc[ADDR_W-1:0];
      s1_row_r    <= row_cur;
      s1_top_r    <= is_top;
      s1_bot_r    <= is_bot;
      s1_border_r <= is_border;
    end
    fw_addr_r <= mem_req.wr_addr;
    fw_data_r <= mem_req.wr_data;
    if (s1_valid_r) begin
      left_r <= ctr;
    end
  end

  // forward the write that lands in the same cycle as the read
  always_comb begin
    ent = rd_a;
    if (fw_valid_r && fw_addr_r == s1_col_r[ADDR_W-1:0]) begin
      ent = fw_data_r;
    end
    rt = rd_b.one;
    if (fw_valid_r && fw_addr_r == s1_colp1_r) begin
      rt = fw_data_r.one;
    end
    ctr   = ent.one;
    sharp = sharpen_px(ctr, ent.two, s1_cur_r, left_r, rt);
  end

  always_comb begin
    mem_req.rd_en        = in_acc;
    mem_req.rd_addr_a    = col_cur[ADDR_W-1:0];
    mem_req.rd_addr_b    = col_inc[ADDR_W-1:0];
    mem_req.wr_en        = s1_valid_r;
    mem_req.wr_addr      = s1_col_r[ADDR_W-1:0];
    mem_req.wr_data.two  = ctr;
    mem_req.wr_data.one  = s1_cur_r;
  end

  always_comb begin
    push.valid       = s1_valid_r;
    push.two         = !s1_top_r && s1_bot_r;
    push.second.pix  = s1_cur_r;
    push.second.row  = s1_row_r;
    push.second.col  = s1_col_r;
    push.second.last = 1'b1;
    push.first.col   = s1_col_r;
    if (s1_top_r) begin
      push.first.pix  = s1_cur_r;
      push.first.row  = s1_row_r;
      push.first.last = 1'b1;
    end else begin
      push.first.pix  = s1_border_r ? ctr : sharp;
      push.first.row  = s1_row_r - ROW_W'(1);
      push.first.last = !s1_bot_r;
    end
  end

  shp3x3_line_mem u_line_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  shp3x3_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_tvalid & out_tready),
    .head  (head),
    .level (level)
  );

  assign out_tvalid = (level != '0);
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, head.col, head.row,
                       head.pix.blue, head.pix.green, head.pix.red};
  assign out_tlast  = head.last;

endmodule

### hw/rtl/shp3x3_checker.sv
`include "assert_macros.svh"

module shp3x3_checker
  import shp3x3_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result stays offered
  `SHP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its payload
  `SHP_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))

  // row 0 results are always the only result of their input
  `SHP_ASSERT_NOW(a_row0_last, out_tvalid && out_tdata[39:24] == 16'd0, out_tlast)

  // reset empties the queue and opens the input
  `SHP_ASSERT_RST_NXT(a_reset_empty, !rst_n, !out_tvalid && in_tready)

endmodule

bind sharpen_3x3_rgb_filter shp3x3_checker u_shp3x3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### tb/sharpen_checker.sv
`timescale 1ns / 100ps
module sharpen_checker
  import shp3x3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  input  logic                   in_tuser,   // frame_start
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // out_red, out_green, out_blue, out_row, out_col
  input  logic                   out_tlast,  // last_in_run
  output int                     fail_cnt,
  output int                     due_cnt
);

  logic [CW_W-1:0]  width_reg;
  logic [ROW_W-1:0] height_reg;
  pix_t             line_one [MAX_WIDTH];
  pix_t             line_two [MAX_WIDTH];
  pix_t             left_px;
  int unsigned      col_pos;
  int unsigned      row_pos;
  res_t             sharp_due [$];
  res_t             got;
  res_t             want;
  int               errs;

  function automatic chan_t sharp_chan(int ctr, int up, int dn, int lf, int rt);
    int v;
    v = 5 * ctr - up - dn - lf - rt;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return chan_t'(v);
  endfunction

  function automatic pix_t sharp_pix(pix_t ctr, pix_t up, pix_t dn, pix_t lf, pix_t rt);
    pix_t p;
    p.red   = sharp_chan(ctr.red, up.red, dn.red, lf.red, rt.red);
    p.green = sharp_chan(ctr.green, up.green, dn.green, lf.green, rt.green);
    p.blue  = sharp_chan(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
    return p;
  endfunction

  task automatic predict_sharpen(input logic sof, input pix_t cur);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned n;
    pix_t        ctr;
    pix_t        res;
    res_t        outs [2];
    w = width_reg;
    if (w < 3) begin
      w = 3;
    end else if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    h = height_reg;
    if (h < 3) begin
      h = 3;
    end
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    n = 0;
    if (r == 0) begin
      outs[n] = '{cur, ROW_W'(r), COL_W'(c), 1'b0};
      n++;
    end else begin
      ctr = line_one[c];
      // borders pass through; positions past a shrunk size count as border
      if (r - 1 == 0 || r - 1 >= h - 1 || c == 0 || c >= w - 1) begin
        res = ctr;
      end else begin
        res = sharp_pix(ctr, line_two[c], cur, left_px, line_one[c + 1]);
      end
      outs[n] = '{res, ROW_W'(r - 1), COL_W'(c), 1'b0};
      n++;
      // last row: the new pixel follows the one above it
      if (r >= h - 1) begin
        outs[n] = '{cur, ROW_W'(r), COL_W'(c), 1'b0};
        n++;
      end
    end
    outs[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      sharp_due.push_back(outs[i]);
    end
    left_px     = line_one[c];
    line_two[c] = line_one[c];
    line_one[c] = cur;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = W_RST;
      height_reg = H_RST;
      col_pos    = 0;
      row_pos    = 0;
      sharp_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_wdata[CW_W-1:0];
        end else if (cfg_index == REG_HEIGHT) begin
          height_reg = cfg_wdata[ROW_W-1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        predict_sharpen(in_tuser, {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]});
      end
      if (out_tvalid && out_tready) begin
        got.pix  = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]};
        got.row  = out_tdata[PIX_W +: ROW_W];
        got.col  = out_tdata[PIX_W + ROW_W +: COL_W];
        got.last = out_tlast;
        if (sharp_due.size() == 0) begin
          $error("result transaction with nothing pending: row %0d col %0d",
                 got.row, got.col);
          errs++;
        end else begin
          want = sharp_due.pop_front();
          check_field("out_red", want.pix.red, got.pix.red);
          check_field("out_green", want.pix.green, got.pix.green);
          check_field("out_blue", want.pix.blue, got.pix.blue);
          check_field("out_row", want.row, got.row);
          check_field("out_col", want.col, got.col);
          check_field("last_in_run", want.last, got.last);
        end
      end
    end
    due_cnt  <= sharp_due.size();
    fail_cnt <= errs;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top
  import shp3x3_pkg::*;
();

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [0:0]             cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // red, green, blue
  logic                   in_tuser;   // frame_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_red, out_green, out_blue, out_row, out_col
  logic                   out_tlast;  // last_in_run
  int                     fail_cnt;
  int                     due_cnt;

  logic        long_hold;
  logic        steady;
  logic        need_sof;
  int unsigned fw;
  int unsigned fh;
  int          burst_left;

  always #6 clk = ~clk;

  sharpen_3x3_rgb_filter dut (.*);

  sharpen_checker u_chk (.*);

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_px();
    pix_t p;
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    return p;
  endfunction

  task automatic put_px(input logic sof, input pix_t px);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady) begin
        gap = 0;
      end else begin
        case ($urandom_range(0, 5))
          0, 1:    gap = 0;
          5:       gap = $urandom_range(8, 20);
          default: gap = $urandom_range(1, 4);
        endcase
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= sof | need_sof;
    in_tdata  <= {px.blue, px.green, px.red};
    need_sof = 1'b0;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the input until every result is out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    int unsigned nw;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) begin
      nw = 32'(val[CW_W-1:0]);
      if (nw < 3) begin
        nw = 3;
      end else if (nw > MAX_WIDTH) begin
        nw = MAX_WIDTH;
      end
      // wider rows would read line memory never written, so restart the frame
      if (nw > fw) need_sof = 1'b1;
      fw = nw;
    end else begin
      fh = (val < 3) ? 3 : val;
    end
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
  endtask

  initial begin : sink
    int unsigned mode;
    int unsigned seg;
    int unsigned k;
    int unsigned i;
    logic        held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      k    = $urandom_range(2, 5);
      for (i = 0; i < seg; i++) begin
        if (long_hold && !held) begin
          // long back-pressure: output queue fills and input stalls
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (120) @(posedge clk);
        end else begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= (i % k == 0);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stim
    int unsigned i;
    int unsigned cnt;
    int unsigned total;
    int unsigned rand_items;
    logic        mark;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    long_hold <= 1'b0;
    steady     = 1'b0;
    need_sof   = 1'b0;
    fw         = 32'(W_RST);
    fh         = 32'(H_RST);
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame: the one interior pixel saturates high
    set_size(3, 3);
    for (i = 0; i < 9; i++) begin
      put_px(i == 0, (i == 4) ? 24'hFFFFFF : 24'h000000);
    end
    // no mark, counters wrap; red clamps low, green high, blue in range
    for (i = 0; i < 9; i++) begin
      put_px(1'b0, (i == 4) ? {8'h00, 8'h80, 8'h30} : {8'hFF, 8'h01, 8'h0A});
    end
    // restart in the middle of a frame
    put_px(1'b0, rand_px());
    put_px(1'b0, rand_px());
    for (i = 0; i < 4; i++) begin
      put_px(i == 0, rand_px());
    end

    // sizes below the minimum act as 3
    set_size(0, 0);
    for (i = 0; i < 18; i++) begin
      put_px(i == 0, rand_px());
    end

    // oversized width clamps, tallest frame: start of the first row
    set_size(12'hFFF, 16'hFFFF);
    for (i = 0; i < 20; i++) begin
      put_px(i == 0, rand_px());
    end
    // shrink mid-frame, column and then row counters past the size
    set_reg(REG_WIDTH, 5);
    for (i = 0; i < 15; i++) begin
      put_px(1'b0, rand_px());
    end
    set_reg(REG_HEIGHT, 3);
    for (i = 0; i < 7; i++) begin
      put_px(1'b0, rand_px());
    end

    // sender keeps offering while the receiver holds off
    long_hold <= 1'b1;
    steady = 1'b1;
    for (i = 0; i < 40; i++) begin
      put_px(1'b0, rand_px());
    end
    steady = 1'b0;

    rand_items = 124;
    while (rand_items < 180) begin
      if ($urandom_range(0, 1)) begin
        set_size(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 6)));
      end
      total = fw * fh;
      cnt   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
      mark  = ($urandom_range(0, 7) != 0);
      for (i = 0; i < cnt; i++) begin
        put_px(mark && i == 0, rand_px());
      end
      rand_items += cnt;
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
